// ===== hdl/fpru_pkg.sv =====
// ----------------------------------------------------------------------------
// fpru_pkg
// Shared constants and types of the FIFO page replacement unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpru_pkg;

  localparam int FPRU_FRAMES = 16;
  localparam int ADDR_W      = 32;
  localparam int PAGE_W      = 32;
  localparam int CNT32_W     = 32;
  localparam int SLOT_OUT_W  = 4;
  localparam int FIU_W       = 5;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [PAGE_W-1:0] PAGE_SIZE_RST     = 32'd4096;
  localparam logic [FIU_W-1:0]  FRAMES_IN_USE_RST = 5'd16;

  // register index, taken from paddr[2]
  localparam logic REG_PAGE_SIZE     = 1'b0;
  localparam logic REG_FRAMES_IN_USE = 1'b1;

  // search token travelling down the cell chain
  typedef struct packed {
    logic              go;
    logic              hit;
    logic [PAGE_W-1:0] key;
  } srch_t;

  // frame write request
  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] page;
  } wr_t;

endpackage

// ===== hdl/fpru_div.sv =====
// ----------------------------------------------------------------------------
// fpru_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpru_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fpru_pkg::ADDR_W-1:0] dividend,
  input  logic [fpru_pkg::PAGE_W-1:0] divisor,
  output logic                       done,
  output logic [fpru_pkg::PAGE_W-1:0] quotient
);
  import fpru_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PAGE_W-1:0] rem_r, rem_nxt;
  logic [ADDR_W-1:0] quot_r, quot_nxt;
  logic [PAGE_W:0]   shifted;
  logic [PAGE_W:0]   trial;

  always_comb begin
    shifted  = {rem_r, quot_r[ADDR_W-1]};
    trial    = shifted - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quot_nxt = dividend;
    end else if (busy_r) begin
      if (!trial[PAGE_W]) begin
        rem_nxt  = trial[PAGE_W-1:0];
        quot_nxt = {quot_r[ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[PAGE_W-1:0];
        quot_nxt = {quot_r[ADDR_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(ADDR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

// ===== hdl/fpru_cell.sv =====
// ----------------------------------------------------------------------------
// fpru_cell
// One frame slot: holds a page and its valid bit, checks the passing search
// token against it and hands the token on to the next slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpru_cell #(
  parameter int FRAMES = fpru_pkg::FPRU_FRAMES,
  parameter int IDX    = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(FRAMES+1)-1:0]         n_active,
  input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)-1:0] wr_slot,
  input  fpru_pkg::wr_t                       wr,
  input  fpru_pkg::srch_t                     srch_i,
  output fpru_pkg::srch_t                     srch_o
);
  import fpru_pkg::*;

  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [PAGE_W-1:0] page_r;
  logic              valid_r;
  srch_t             srch_r, srch_nxt;
  logic              match;

  assign match = valid_r && (CNT_W'(IDX) < n_active) && (page_r == srch_i.key);

  always_comb begin
    srch_nxt     = srch_i;
    srch_nxt.hit = srch_i.hit | (srch_i.go & match);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      srch_r.go <= 1'b0;
    end else begin
      if (wr.en && wr_slot == SLOT_W'(IDX)) begin
        valid_r <= 1'b1;
      end
      srch_r.go <= srch_nxt.go;
    end
    if (wr.en && wr_slot == SLOT_W'(IDX)) begin
      page_r <= wr.page;
    end
    srch_r.hit <= srch_nxt.hit;
    srch_r.key <= srch_nxt.key;
  end

  assign srch_o = srch_r;

endmodule

// ===== hdl/fifo_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit
// FIFO page replacement: page lookup over a chain of frame cells.
// ----------------------------------------------------------------------------
// Each item is one memory address. Its page number comes from a bit-serial
// divider. A search token then walks the chain of frame cells, one cell per
// cycle. The hit is then latched; once the output is free, the result is
// registered on the output and, on a fault, the frames, the FIFO pointer and
// the saturating fault count are updated. The next item is taken only after
// that update, so the unit does not take a new address before it is through
// with the last one, and a stalled output delays it further. A new item is
// taken while the previous result still waits on the output.
// page_size 0 gives page number 0xFFFFFFFF. frames_in_use 0 acts as 1, and
// values above FRAMES act as FRAMES. Configure only while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_page_replacement_unit #(
  parameter int FRAMES = fpru_pkg::FPRU_FRAMES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fpru_pkg::ADDR_W-1:0]       in_memory_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fpru_pkg::PAGE_W-1:0]       out_page_number,
  output logic                              out_page_fault,
  output logic [fpru_pkg::SLOT_OUT_W-1:0]   out_slot_written,
  output logic [fpru_pkg::CNT32_W-1:0]      out_fault_total,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fpru_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [fpru_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [fpru_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import fpru_pkg::*;

  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SRCH, S_UPD} state_t;

  state_t            state_r;
  logic [PAGE_W-1:0] page_size_r;
  logic [FIU_W-1:0]  fiu_r;
  logic [SLOT_W-1:0] oldest_r;
  logic [CNT32_W-1:0] fault_r;
  logic              hit_r;

  logic              out_valid_r;
  logic [PAGE_W-1:0] out_page_r;
  logic              out_fault_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [CNT32_W-1:0] out_total_r;

  logic              accept;
  logic              div_done;
  logic [PAGE_W-1:0] quotient;
  logic [CNT_W-1:0]  n_active;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  slot_inc;
  logic [SLOT_W-1:0] oldest_nxt;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [CNT32_W-1:0] fault_nxt;
  logic              out_free;
  logic              cfg_wr;
  wr_t               wr;
  srch_t             link [0:FRAMES];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= PAGE_SIZE_RST;
      fiu_r       <= FRAMES_IN_USE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_PAGE_SIZE:     page_size_r <= cfg_pwdata;
        REG_FRAMES_IN_USE: fiu_r       <= cfg_pwdata[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_PAGE_SIZE:     cfg_prdata = page_size_r;
      REG_FRAMES_IN_USE: cfg_prdata = {{(CFG_DATA_W-FIU_W){1'b0}}, fiu_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (fiu_r == '0) begin
      n_active = CNT_W'(1);
    end else if (int'(fiu_r) > FRAMES) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(fiu_r);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;

  fpru_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_memory_address),
    .divisor  (page_size_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    link[0].go  = (state_r == S_DIV) && div_done;
    link[0].hit = 1'b0;
    link[0].key = quotient;
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    fpru_cell #(
      .FRAMES (FRAMES),
      .IDX    (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .n_active (n_active),
      .wr_slot  (slot),
      .wr       (wr),
      .srch_i   (link[g]),
      .srch_o   (link[g+1])
    );
  end

  // victim slot and pointer advance
  always_comb begin
    if (CNT_W'(oldest_r) < n_active) begin
      slot = oldest_r;
    end else begin
      slot = '0;
    end
    slot_inc = CNT_W'(slot) + 1'b1;
    if (slot_inc == n_active) begin
      oldest_nxt = '0;
    end else begin
      oldest_nxt = SLOT_W'(slot_inc);
    end
    slot_ext  = {{SLOT_OUT_W{1'b0}}, slot};
    fault_nxt = (fault_r == '1) ? fault_r : fault_r + 1'b1;
  end

  assign out_free = !out_valid_r || out_ready;
  assign wr.en    = (state_r == S_UPD) && out_free && !hit_r;
  assign wr.page  = quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_UPD) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (link[FRAMES].go) begin
            hit_r   <= link[FRAMES].hit;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_page_r  <= quotient;
            out_fault_r <= !hit_r;
            if (hit_r) begin
              out_slot_r  <= '0;
              out_total_r <= fault_r;
            end else begin
              out_slot_r  <= slot_ext[SLOT_OUT_W-1:0];
              out_total_r <= fault_nxt;
              fault_r     <= fault_nxt;
              oldest_r    <= oldest_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_page_number  = out_page_r;
  assign out_page_fault   = out_fault_r;
  assign out_slot_written = out_slot_r;
  assign out_fault_total  = out_total_r;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO page replacement unit.
// ----------------------------------------------------------------------------
// Drives memory addresses through the valid/ready input and checks every
// result against an in-bench FIFO replacement predictor (page division,
// frame search, pointer wrap, saturating fault count). A directed warm-up
// covers field extremes, zero page size, frame counts out of range and a
// pointer left beyond the frame count; random phases follow with several
// register settings and varying sender/receiver idle ratios.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import fpru_pkg::*;

  localparam int FRAMES      = FPRU_FRAMES;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_TAIL  = 60;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;
  localparam int POOL_DEPTH  = 24;

  typedef struct packed {
    logic [PAGE_W-1:0]     page;
    logic                  fault;
    logic [SLOT_OUT_W-1:0] slot;
    logic [CNT32_W-1:0]    total;
  } lookup_t;

  class fault_scoreboard;
    logic [PAGE_W-1:0]  page_size;
    logic [FIU_W-1:0]   frames_cfg;
    logic [PAGE_W-1:0]  frame_page [FRAMES];
    bit                 frame_used [FRAMES];
    int unsigned        victim;
    logic [CNT32_W-1:0] faults;
    lookup_t            lookups [$];
    int                 mismatches;

    function new();
      page_size  = PAGE_SIZE_RST;
      frames_cfg = FRAMES_IN_USE_RST;
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i] = '0;
        frame_used[i] = 1'b0;
      end
      victim     = 0;
      faults     = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_PAGE_SIZE) begin
        page_size = value;
      end else begin
        frames_cfg = value[FIU_W-1:0];
      end
    endfunction

    function int unsigned active_frames();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > FRAMES) return FRAMES;
      return frames_cfg;
    endfunction

    function void take_address(logic [ADDR_W-1:0] addr);
      lookup_t     res;
      int unsigned n;
      int unsigned slot;
      bit          hit;
      n    = active_frames();
      hit  = 1'b0;
      slot = 0;
      res.page = (page_size == 0) ? '1 : addr / page_size;
      for (int i = 0; i < n; i++) begin
        if (!hit && frame_used[i] && frame_page[i] == res.page) hit = 1'b1;
      end
      if (!hit) begin
        slot = (victim < n) ? victim : 0;
        frame_page[slot] = res.page;
        frame_used[slot] = 1'b1;
        victim = (slot + 1) % n;
        if (faults != '1) faults = faults + 1'b1;
      end
      res.fault = !hit;
      res.slot  = hit ? '0 : slot[SLOT_OUT_W-1:0];
      res.total = faults;
      lookups.push_back(res);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, actual %h", field, want, got);
    endfunction

    function void check_result(logic [PAGE_W-1:0] page, logic fault,
                               logic [SLOT_OUT_W-1:0] slot, logic [CNT32_W-1:0] total);
      lookup_t want;
      if (lookups.size() == 0) begin
        report("unexpected item page_number", 'x, page);
        return;
      end
      want = lookups.pop_front();
      if (want.page !== page) report("page_number", want.page, page);
      if (want.fault !== fault) report("page_fault", 32'(want.fault), 32'(fault));
      if (want.slot !== slot) report("slot_written", 32'(want.slot), 32'(slot));
      if (want.total !== total) report("fault_total", want.total, total);
    endfunction

    function int pending();
      return lookups.size();
    endfunction

    function bit clean();
      return mismatches == 0 && lookups.size() == 0;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     in_memory_address = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PAGE_W-1:0]     out_page_number;
  logic                  out_page_fault;
  logic [SLOT_OUT_W-1:0] out_slot_written;
  logic [CNT32_W-1:0]    out_fault_total;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  fault_scoreboard sb = new();
  int              src_idle_pct = 0;
  int              sink_stall_pct = 0;
  int              cycle_count = 0;
  logic [PAGE_W-1:0] page_pool [POOL_DEPTH];
  int              pool_span = 1;

  fifo_page_replacement_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_memory_address (in_memory_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_page_number   (out_page_number),
    .out_page_fault    (out_page_fault),
    .out_slot_written  (out_slot_written),
    .out_fault_total   (out_fault_total),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_address(in_memory_address);
      if (out_valid && out_ready)
        sb.check_result(out_page_number, out_page_fault, out_slot_written, out_fault_total);
    end
  end

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_memory_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  function automatic logic [PAGE_W-1:0] random_page();
    if (sb.page_size == 0) return '1;
    return $urandom / sb.page_size;
  endfunction

  // mostly addresses inside a small working set of pages, so hits occur
  function automatic logic [ADDR_W-1:0] next_address();
    logic [63:0] addr64;
    int          idx;
    if ($urandom_range(3) == 0 || sb.page_size == 0) return $urandom;
    idx = $urandom_range(pool_span - 1);
    if ($urandom_range(9) == 0) page_pool[idx] = random_page();
    addr64 = 64'(page_pool[idx]) * 64'(sb.page_size) + 64'($urandom % sb.page_size);
    if (addr64 > 64'hFFFF_FFFF) return $urandom;
    return addr64[31:0];
  endfunction

  initial begin
    logic [31:0] psize;
    logic [31:0] frames;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_address(32'h0000_0000);
    send_address(32'h0000_0FFF);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_1000);
    send_address(32'h0000_1ABC);
    send_address(32'h7FFF_FFFF);
    send_address(32'h8000_0000);
    drain_results();
    // pointer now beyond the new frame count
    write_register(REG_FRAMES_IN_USE, 32'd2);
    send_address(32'h1234_5678);
    send_address(32'hFFFF_FFFF);
    drain_results();
    write_register(REG_PAGE_SIZE, 32'd0);
    write_register(REG_FRAMES_IN_USE, 32'd0);
    send_address(32'h0000_0000);
    send_address(32'hABCD_EF01);
    drain_results();
    write_register(REG_PAGE_SIZE, 32'd1);
    write_register(REG_FRAMES_IN_USE, 32'd31);
    send_address(32'hFFFF_FFFF);
    send_address(32'h0000_0005);
    send_address(32'h0000_0005);
    drain_results();
    write_register(REG_PAGE_SIZE, 32'hFFFF_FFFF);
    write_register(REG_FRAMES_IN_USE, 32'd17);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFFE);
    send_address(32'h5555_5555);
    send_address(32'hAAAA_AAAA);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin psize = 32'd4096;                frames = 32'd16; end
        1: begin psize = 32'd1;                   frames = 32'd1;  end
        2: begin psize = 32'hFFFF_FFFF;           frames = 32'd31; end
        3: begin psize = 32'd0;                   frames = 32'd0;  end
        4: begin psize = $urandom_range(2, 500);  frames = 32'd5;  end
        5: begin psize = 32'd64;                  frames = $urandom_range(0, 31); end
        6: begin psize = $urandom;                frames = 32'd17; end
        default: begin psize = 32'd3;             frames = 32'd2;  end
      endcase
      write_register(REG_PAGE_SIZE, psize);
      write_register(REG_FRAMES_IN_USE, frames);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
        default: begin src_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      pool_span = sb.active_frames() + $urandom_range(0, 6);
      if (pool_span > POOL_DEPTH) pool_span = POOL_DEPTH;
      for (int i = 0; i < POOL_DEPTH; i++) page_pool[i] = random_page();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(149) == 0) drain_results();
        send_address(next_address());
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.clean()) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
